// ===== rtl/core/oll_pkg.sv =====
// Shared types and codes for the object line loader.
// Depends on nothing; the front end, back end, top level and testbench import it.
package oll_pkg;

  localparam int ADDR_W = 12;
  localparam int LINE_W = 16;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_EOL  = 2'd1;
  localparam logic [1:0] MODE_EOF  = 2'd2;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] line;
    logic              ok;
  } job_info_t;

endpackage

// ===== rtl/core/oll_front.sv =====
// Object line loader front end: checks each character, builds at most one job per line.
// Depends on oll_pkg.
module oll_front import oll_pkg::*; #(
  parameter int MEM_BYTES = 4096,
  parameter int BPL       = 10,
  parameter int CNT_W     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [1:0]            mode,
  input  logic [7:0]            char_code,
  output logic                  job_push,
  output job_info_t             job_info,
  output logic [CNT_W-1:0]      job_count,
  output logic [BPL-1:0][7:0]   job_bytes
);

  localparam int IDX_W = (BPL > 1) ? $clog2(BPL) : 1;
  localparam logic [4:0] DATA_START = 5'd7;
  localparam logic [4:0] DATA_END   = 5'(7 + 2 * BPL);
  localparam logic [4:0] BAR_COL    = 5'(8 + 2 * BPL);
  localparam logic [4:0] MIN_COLS   = 5'(9 + 2 * BPL);
  localparam logic [4:0] COL_MAX    = 5'd31;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_A       = 8'd97;
  localparam logic [7:0] CH_F       = 8'd102;
  localparam logic [7:0] CH_X       = 8'd120;
  localparam logic [7:0] CH_COLON   = 8'd58;
  localparam logic [7:0] CH_BAR     = 8'd124;

  logic [4:0]         column;
  logic [BPL-1:0][7:0] line_bytes;
  logic [CNT_W-1:0]   byte_count;
  logic [3:0]         high_nibble;
  logic [ADDR_W-1:0]  line_address;
  logic [ADDR_W:0]    previous_end;
  logic               fixed_bad;
  logic               addr_bad;
  logic               nonblank;
  logic               has_data;
  logic               data_ended;
  logic               data_bad;
  logic [LINE_W-1:0]  line_counter;
  logic               load_failed;

  logic               is_hex;
  logic [3:0]         nibble;
  logic               is_space;
  logic               first_digit;
  logic [4:0]         data_offset;
  logic               in_data;
  logic               store_byte;
  logic               line_err;
  logic [ADDR_W:0]    line_end;
  logic               write_line;

  always_comb begin
    is_hex = 1'b0;
    nibble = 4'd0;
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      is_hex = 1'b1;
      nibble = 4'(char_code - CH_ZERO);
    end else if (char_code >= CH_A && char_code <= CH_F) begin
      is_hex = 1'b1;
      nibble = 4'(char_code - CH_A + 8'd10);
    end
  end

  assign is_space    = (char_code == CH_SPACE);
  assign data_offset = column - DATA_START;
  assign first_digit = ~data_offset[0];
  assign in_data     = (column >= DATA_START) && (column < DATA_END);
  assign store_byte  = take && (mode == MODE_CHAR) && in_data && !data_ended && is_hex
                       && !first_digit && (byte_count < CNT_W'(BPL));

  assign line_end = {1'b0, line_address} + (ADDR_W + 1)'(byte_count);

  always_comb begin
    line_err = 1'b0;
    if (column < MIN_COLS || fixed_bad) begin
      line_err = 1'b1;
    end
    if (nonblank) begin
      if (addr_bad || {1'b0, line_address} < previous_end) begin
        line_err = 1'b1;
      end
      if (has_data) begin
        if (data_bad || byte_count == '0 || line_end > (ADDR_W + 1)'(MEM_BYTES)) begin
          line_err = 1'b1;
        end
      end
    end
  end

  assign write_line = has_data && (byte_count != '0);

  always_comb begin
    job_push  = 1'b0;
    job_info  = '0;
    job_count = byte_count;
    job_bytes = line_bytes;
    if (take && mode == MODE_EOL && !load_failed) begin
      if (line_err) begin
        job_push      = 1'b1;
        job_info.kind = KIND_ERROR;
        job_info.line = line_counter;
      end else if (write_line) begin
        job_push      = 1'b1;
        job_info.kind = KIND_WRITE;
        job_info.addr = line_address;
      end
    end else if (take && mode == MODE_EOF) begin
      job_push      = 1'b1;
      job_info.kind = KIND_FINISH;
      job_info.ok   = !load_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (store_byte) begin
      line_bytes[byte_count[IDX_W-1:0]] <= {high_nibble, nibble};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      byte_count   <= '0;
      high_nibble  <= '0;
      line_address <= '0;
      previous_end <= '0;
      fixed_bad    <= 1'b0;
      addr_bad     <= 1'b0;
      nonblank     <= 1'b0;
      has_data     <= 1'b0;
      data_ended   <= 1'b0;
      data_bad     <= 1'b0;
      line_counter <= LINE_W'(1);
      load_failed  <= 1'b0;
    end else if (take) begin
      unique case (mode)
        MODE_CHAR: begin
          if (column < COL_MAX) begin
            column <= column + 5'd1;
          end
          if (column < DATA_END && !is_space) begin
            nonblank <= 1'b1;
          end
          if (column == 5'd0) begin
            if (char_code != CH_ZERO) addr_bad <= 1'b1;
          end else if (column == 5'd1) begin
            if (char_code != CH_X) addr_bad <= 1'b1;
          end else if (column >= 5'd2 && column <= 5'd4) begin
            if (!is_hex) begin
              addr_bad <= 1'b1;
            end else if (column == 5'd2) begin
              line_address <= ADDR_W'(nibble);
            end else begin
              line_address <= {line_address[ADDR_W-5:0], nibble};
            end
          end else if (column == 5'd5) begin
            if (char_code != CH_COLON) addr_bad <= 1'b1;
          end else if (column == 5'd6) begin
            if (!is_space) fixed_bad <= 1'b1;
          end else if (in_data) begin
            if (!is_space) has_data <= 1'b1;
            if (data_ended) begin
              if (!is_space) data_bad <= 1'b1;
            end else if (first_digit && is_space) begin
              data_ended <= 1'b1;
            end else if (!is_hex) begin
              data_bad <= 1'b1;
            end else if (first_digit) begin
              high_nibble <= nibble;
            end else if (store_byte) begin
              byte_count <= byte_count + CNT_W'(1);
            end
          end else if (column == DATA_END) begin
            if (!is_space) fixed_bad <= 1'b1;
          end else if (column == BAR_COL) begin
            if (char_code != CH_BAR) fixed_bad <= 1'b1;
          end
        end
        MODE_EOL: begin
          if (!load_failed) begin
            if (line_err) begin
              load_failed <= 1'b1;
            end else if (write_line) begin
              previous_end <= line_end;
            end
          end
          if (line_counter != {LINE_W{1'b1}}) begin
            line_counter <= line_counter + LINE_W'(1);
          end
          column       <= '0;
          byte_count   <= '0;
          high_nibble  <= '0;
          line_address <= '0;
          fixed_bad    <= 1'b0;
          addr_bad     <= 1'b0;
          nonblank     <= 1'b0;
          has_data     <= 1'b0;
          data_ended   <= 1'b0;
          data_bad     <= 1'b0;
        end
        MODE_EOF: begin
          column       <= '0;
          byte_count   <= '0;
          high_nibble  <= '0;
          line_address <= '0;
          previous_end <= '0;
          fixed_bad    <= 1'b0;
          addr_bad     <= 1'b0;
          nonblank     <= 1'b0;
          has_data     <= 1'b0;
          data_ended   <= 1'b0;
          data_bad     <= 1'b0;
          line_counter <= LINE_W'(1);
          load_failed  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Once a line has failed, only the finish word may still be queued.
  a_sticky_fail: assert property (@(posedge clk) disable iff (rst)
    job_push && load_failed |-> job_info.kind == KIND_FINISH)
    else $error("job queued after a line error");

  // A write job always carries at least one byte inside memory.
  a_write_bounds: assert property (@(posedge clk) disable iff (rst)
    job_push && job_info.kind == KIND_WRITE |->
      job_count != '0 && line_end <= (ADDR_W + 1)'(MEM_BYTES))
    else $error("write job out of bounds");

endmodule

// ===== rtl/core/oll_job_queue.sv =====
// Two-entry queue of line jobs between the front and back ends.
// Depends on nothing beyond its width parameter.
module oll_job_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("job queue underflow");

endmodule

// ===== rtl/core/oll_back.sv =====
// Back end of the object line loader: expands each job into result words, one per cycle while the output is popped.
// Depends on oll_pkg.
module oll_back import oll_pkg::*; #(
  parameter int BPL   = 10,
  parameter int CNT_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  job_info_t           job_info,
  input  logic [CNT_W-1:0]    job_count,
  input  logic [BPL-1:0][7:0] job_bytes,
  output logic                job_pop,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          kind,
  output logic [ADDR_W-1:0]   write_address,
  output logic [7:0]          write_byte,
  output logic [LINE_W-1:0]   line_number,
  output logic                load_ok,
  output logic                last_of_run
);

  localparam int IDX_W = (BPL > 1) ? $clog2(BPL) : 1;

  logic             out_valid;
  logic [CNT_W-1:0] idx;
  logic             is_write;
  logic             last;
  logic             load;

  assign is_write = (job_info.kind == KIND_WRITE);
  assign last     = !is_write || (CNT_W'(idx + CNT_W'(1)) == job_count);
  assign load     = job_valid && (!out_valid || pop);
  assign job_pop  = load && last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= job_info.kind;
      write_address <= job_info.addr + ADDR_W'(idx);
      write_byte    <= is_write ? job_bytes[idx[IDX_W-1:0]] : 8'd0;
      line_number   <= job_info.line;
      load_ok       <= job_info.ok;
      last_of_run   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid && is_write |-> idx < job_count)
    else $error("byte index past the line's byte count");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_WRITE |-> last_of_run)
    else $error("error or finish word not marked last");

endmodule

// ===== rtl/core/object_line_loader.sv =====
// Object line loader: an end-of-line or end-of-file word that causes results shows its first
// result once it has passed the job queue and the output register; one input word is taken
// every cycle, one result leaves every cycle while popped, and a line of N bytes drains as N
// result words as later text is parsed. Input stalls only when the two-entry line-job queue
// is full. Reset is synchronous and clears all control state; no clearing pass is needed.
module object_line_loader import oll_pkg::*; #(
  parameter int MEM_BYTES      = 4096,
  parameter int BYTES_PER_LINE = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic [7:0]        char_code,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_byte,
  output logic [LINE_W-1:0] line_number,
  output logic              load_ok,
  output logic              last_of_run
);

  localparam int CNT_W   = $clog2(BYTES_PER_LINE + 1);
  localparam int JOB_W   = $bits(job_info_t) + CNT_W + 8 * BYTES_PER_LINE;

  logic                           take;
  logic                           f_push;
  job_info_t                      f_info;
  logic [CNT_W-1:0]               f_count;
  logic [BYTES_PER_LINE-1:0][7:0] f_bytes;
  logic                           q_valid;
  logic                           q_pop;
  logic [JOB_W-1:0]               q_head;
  job_info_t                      b_info;
  logic [CNT_W-1:0]               b_count;
  logic [BYTES_PER_LINE-1:0][7:0] b_bytes;

  assign take = push && !full;
  assign {b_info, b_count, b_bytes} = q_head;

  oll_front #(
    .MEM_BYTES (MEM_BYTES),
    .BPL       (BYTES_PER_LINE),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .char_code (char_code),
    .job_push  (f_push),
    .job_info  (f_info),
    .job_count (f_count),
    .job_bytes (f_bytes)
  );

  oll_job_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_info, f_count, f_bytes}),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  oll_back #(
    .BPL   (BYTES_PER_LINE),
    .CNT_W (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_valid),
    .job_info      (b_info),
    .job_count     (b_count),
    .job_bytes     (b_bytes),
    .job_pop       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .kind          (kind),
    .write_address (write_address),
    .write_byte    (write_byte),
    .line_number   (line_number),
    .load_ok       (load_ok),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== sim/object_line_loader_tb.sv =====
// Self-checking testbench for object_line_loader: directed and random object-file text.
// A scoreboard class predicts every result word; depends on oll_pkg and the loader RTL.
`timescale 1ns / 100ps

module object_line_loader_tb;
  import oll_pkg::*;

  localparam int MEM_BYTES = 4096;
  localparam int BYTES_PER_LINE = 10;
  localparam int DATA_START = 7;
  localparam int DATA_END = DATA_START + 2 * BYTES_PER_LINE;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [5:0] FL_FIXED = 6'd1;
  localparam logic [5:0] FL_ADDR = 6'd2;
  localparam logic [5:0] FL_NONBLANK = 6'd4;
  localparam logic [5:0] FL_DATA = 6'd8;
  localparam logic [5:0] FL_ENDED = 6'd16;
  localparam logic [5:0] FL_BADDATA = 6'd32;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [LINE_W-1:0] line;
    logic              ok;
    logic              last;
  } load_result_t;

  class load_scoreboard;
    logic [4:0] col_pos;
    logic [7:0] line_buf[BYTES_PER_LINE];
    int unsigned buf_count;
    logic [3:0] hi_digit;
    logic [11:0] head_addr;
    int unsigned write_floor;
    logic [5:0] flags;
    logic [15:0] line_no;
    bit sticky_fail;
    load_result_t pending_results[$];
    int unsigned mismatches;
    int unsigned writes_seen;
    int unsigned errors_seen;
    int unsigned finishes_seen;

    function new();
      restart_load();
      mismatches = 0;
      writes_seen = 0;
      errors_seen = 0;
      finishes_seen = 0;
    endfunction

    function void clear_line();
      col_pos = 0;
      buf_count = 0;
      hi_digit = 0;
      head_addr = 0;
      flags = 0;
    endfunction

    function void restart_load();
      clear_line();
      write_floor = 0;
      line_no = 1;
      sticky_fail = 0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= 8'd48 && c <= 8'd57) return int'(c) - 48;
      if (c >= 8'd97 && c <= 8'd102) return int'(c) - 87;
      return -1;
    endfunction

    function void add_result(logic [1:0] k, logic [11:0] a, logic [7:0] d, logic [15:0] ln,
                             logic ok);
      load_result_t r;
      r.kind = k;
      r.addr = a;
      r.data = d;
      r.line = ln;
      r.ok = ok;
      r.last = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void take_char(logic [7:0] c);
      int unsigned col;
      int v;
      bit first;
      col = col_pos;
      v = hex_digit(c);
      if (col_pos < 5'd31) col_pos++;
      if (col < DATA_END && c != " ") flags |= FL_NONBLANK;
      if (col == 0) begin
        if (c != "0") flags |= FL_ADDR;
      end else if (col == 1) begin
        if (c != "x") flags |= FL_ADDR;
      end else if (col <= 4) begin
        if (v < 0) flags |= FL_ADDR;
        else if (col == 2) head_addr = 12'(v);
        else head_addr = {head_addr[7:0], 4'(v)};
      end else if (col == 5) begin
        if (c != ":") flags |= FL_ADDR;
      end else if (col == 6) begin
        if (c != " ") flags |= FL_FIXED;
      end else if (col < DATA_END) begin
        first = ((col - DATA_START) % 2) == 0;
        if (c != " ") flags |= FL_DATA;
        if ((flags & FL_ENDED) != 0) begin
          if (c != " ") flags |= FL_BADDATA;
        end else if (first && c == " ") begin
          flags |= FL_ENDED;
        end else if (v < 0) begin
          flags |= FL_BADDATA;
        end else if (first) begin
          hi_digit = 4'(v);
        end else if (buf_count < BYTES_PER_LINE) begin
          line_buf[buf_count] = {hi_digit, 4'(v)};
          buf_count++;
        end
      end else if (col == DATA_END) begin
        if (c != " ") flags |= FL_FIXED;
      end else if (col == DATA_END + 1) begin
        if (c != "|") flags |= FL_FIXED;
      end
    endfunction

    function void close_line();
      bit bad;
      int unsigned i;
      bad = (col_pos < DATA_END + 2) || ((flags & FL_FIXED) != 0);
      if ((flags & FL_NONBLANK) != 0) begin
        if ((flags & FL_ADDR) != 0) bad = 1;
        else if (head_addr < write_floor) bad = 1;
        if ((flags & FL_DATA) != 0) begin
          if ((flags & FL_BADDATA) != 0) bad = 1;
          else if (buf_count == 0) bad = 1;
          else if (head_addr + buf_count > MEM_BYTES) bad = 1;
        end
      end
      if (!sticky_fail) begin
        if (bad) begin
          add_result(KIND_ERROR, 0, 0, line_no, 1'b0);
          sticky_fail = 1;
        end else if ((flags & FL_DATA) != 0 && buf_count > 0) begin
          for (i = 0; i < buf_count; i++)
            add_result(KIND_WRITE, 12'(head_addr + i), line_buf[i], 0, 1'b0);
          write_floor = head_addr + buf_count;
        end
      end
      if (line_no != 16'hffff) line_no++;
      clear_line();
    endfunction

    function void note_word(logic [1:0] m, logic [7:0] c);
      int unsigned prior_count;
      load_result_t r;
      prior_count = pending_results.size();
      case (m)
        MODE_CHAR: take_char(c);
        MODE_EOL: close_line();
        MODE_EOF: begin
          add_result(KIND_FINISH, 0, 0, 0, !sticky_fail);
          restart_load();
        end
        default: ;
      endcase
      if (pending_results.size() > prior_count) begin
        r = pending_results.pop_back();
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    endfunction

    function void check_result(load_result_t got);
      load_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind %0d addr %h byte %h line %0d ok %b last %b",
                   $time, got.kind, got.addr, got.data, got.line, got.ok, got.last);
        return;
      end
      want = pending_results.pop_front();
      case (want.kind)
        KIND_WRITE: writes_seen++;
        KIND_ERROR: errors_seen++;
        default: finishes_seen++;
      endcase
      if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data ||
          got.line !== want.line || got.ok !== want.ok || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected kind %0d addr %h byte %h line %0d ok %b last %b",
                   $time, want.kind, want.addr, want.data, want.line, want.ok, want.last);
          $display("%0t:      got kind %0d addr %h byte %h line %0d ok %b last %b",
                   $time, got.kind, got.addr, got.data, got.line, got.ok, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] mode = MODE_CHAR;
  logic [7:0] char_code = 8'd0;
  logic full;
  logic empty;
  logic [1:0] kind;
  logic [ADDR_W-1:0] write_address;
  logic [7:0] write_byte;
  logic [LINE_W-1:0] line_number;
  logic load_ok;
  logic last_of_run;

  load_scoreboard board;
  logic [7:0] line_text[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned spare_rate = 0;
  int unsigned words_sent = 0;
  int unsigned lines_sent = 0;

  object_line_loader uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .char_code(char_code),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .write_address(write_address),
    .write_byte(write_byte),
    .line_number(line_number),
    .load_ok(load_ok),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("object_line_loader verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        board.check_result({kind, write_address, write_byte, line_number, load_ok, last_of_run});
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic [1:0] m, input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_word(m, c);
    words_sent++;
  endtask

  task automatic send_line(input bit with_eol);
    int unsigned i;
    for (i = 0; i < line_text.size(); i++) begin
      if (spare_rate != 0 && $urandom_range(99) < spare_rate)
        send_word(MODE_SPARE, 8'($urandom_range(255)));
      send_word(MODE_CHAR, line_text[i]);
    end
    if (with_eol) send_word(MODE_EOL, 8'($urandom_range(255)));
    lines_sent++;
  endtask

  task automatic end_file();
    send_word(MODE_EOF, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void append_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_text.push_back(s[i]);
  endfunction

  function automatic void form_line(string head, string data);
    line_text.delete();
    append_text(head);
    append_text(data);
    while (line_text.size() < DATA_END + 1) line_text.push_back(" ");
    line_text.push_back("|");
  endfunction

  function automatic void data_line(int unsigned addr, int unsigned nbytes);
    string s;
    logic [7:0] b;
    int unsigned i;
    s = "";
    for (i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(255));
      s = {s, $sformatf("%h", b)};
    end
    form_line($sformatf("0x%h: ", 12'(addr)), s);
  endfunction

  function automatic void add_comment(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) line_text.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void mangle_line();
    int unsigned at;
    if ($urandom_range(1) == 0) begin
      at = $urandom_range(line_text.size() - 1);
      line_text[at] = 8'($urandom_range(255));
    end else begin
      at = $urandom_range(DATA_END - 1, DATA_START);
      case ($urandom_range(3))
        0: line_text[at] = " ";
        1: line_text[at] = 8'("A" + $urandom_range(5));
        2: line_text[at] = 8'("g" + $urandom_range(19));
        default: line_text[at] = 8'($urandom_range(127, 32));
      endcase
    end
  endfunction

  task automatic random_files(input int unsigned word_target);
    int unsigned goal;
    int unsigned cursor;
    int unsigned addr;
    int unsigned nb;
    int unsigned file_lines;
    int unsigned pick;
    int unsigned k;
    int unsigned keep;
    bit short_line;
    goal = words_sent + word_target;
    while (words_sent < goal) begin
      cursor = ($urandom_range(9) == 0) ? $urandom_range(4090, 3900) : $urandom_range(64);
      file_lines = $urandom_range(3, 1);
      for (k = 0; k < file_lines && words_sent < goal; k++) begin
        pick = $urandom_range(99);
        nb = $urandom_range(BYTES_PER_LINE, 1);
        addr = cursor + (($urandom_range(3) == 0) ? $urandom_range(40) : 0);
        if (addr > MEM_BYTES - 1) addr = MEM_BYTES - nb;
        short_line = 0;
        if (pick < 60) begin
          data_line(addr, nb);
          cursor = addr + nb;
        end else if (pick < 68) begin
          form_line("       ", "");
        end else if (pick < 76) begin
          form_line($sformatf("0x%h: ", 12'(addr)), "");
        end else if (pick < 88) begin
          data_line(addr, nb);
          mangle_line();
        end else if (pick < 94) begin
          data_line(addr, nb);
          keep = $urandom_range(DATA_END + 1);
          while (line_text.size() > keep) void'(line_text.pop_back());
          short_line = 1;
        end else begin
          data_line((cursor > 0) ? $urandom_range(cursor - 1) : 0, nb);
        end
        if (!short_line && $urandom_range(1) == 1) add_comment($urandom_range(12));
        send_line(!(k == file_lines - 1 && $urandom_range(9) == 0));
      end
      end_file();
    end
  endtask

  task automatic directed_lines();
    form_line("0x000: ", "00ff123456789abcdef0");
    send_line(1);
    form_line("0x00a: ", "a5");
    append_text(" ok");
    line_text.push_back(8'hff);
    send_word(MODE_SPARE, 8'hff);
    send_line(1);
    form_line("0x005: ", "11");
    send_line(1);
    end_file();

    line_text.delete();
    append_text("0x030: 12");
    send_line(1);
    end_file();

    form_line("0xff8: ", "0102030405060708");
    send_line(1);
    end_file();

    form_line("0x050: ", "cd");
    send_line(0);
    end_file();
    end_file();
  endtask

  initial begin
    int unsigned guard;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 9;
    recv_idle = 77;
    directed_lines();
    wait_drained();
    spare_rate = 2;
    random_files(30);
    wait_drained();

    send_idle = 77;
    recv_idle = 9;
    random_files(30);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    random_files(30);

    push <= 1'b0;
    guard = 0;
    while (board.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.pending_results.size() != 0)
      $display("%0d expected results never arrived", board.pending_results.size());
    $display("Sent %0d words in %0d text lines under three idle profiles.", words_sent,
             lines_sent);
    $display("Checked %0d byte writes, %0d line errors and %0d load finishes.",
             board.writes_seen, board.errors_seen, board.finishes_seen);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("object_line_loader verification clean");
    else
      $display("object_line_loader verification failed");
    $finish;
  end

endmodule

// ===== object_line_loader.f =====
rtl/core/oll_pkg.sv
rtl/core/oll_front.sv
rtl/core/oll_job_queue.sv
rtl/core/oll_back.sv
rtl/core/object_line_loader.sv
sim/object_line_loader_tb.sv
